// File: src/assert_macros.svh
// Shared assertion helpers. Every user has clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define TBLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define TBLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tblc_pkg.sv
package tblc_pkg;

  typedef logic [5:0] hold_cnt_t;
  typedef logic [7:0] light_cnt_t;
  typedef logic [5:0] step_t;
  typedef logic [6:0] tick_t;
  typedef logic [5:0] sec_t;
  typedef logic [7:0] min_t;
  typedef logic [7:0] level_t;
  typedef logic [7:0] cfg_data_t;
  typedef logic [1:0] cfg_addr_t;

  localparam hold_cnt_t  HoldCap      = 6'd60;
  localparam light_cnt_t LightCap     = 8'd255;
  localparam step_t      StepMax      = 6'd60;
  localparam step_t      StepMin      = 6'd1;
  localparam step_t      RomLast      = 6'd40;
  localparam int         RomDepth     = 41;
  localparam tick_t      TicksPerSec  = 7'd100;
  localparam tick_t      BlinkTicks   = 7'd20;
  localparam sec_t       SecsPerMin   = 6'd60;
  localparam cfg_data_t  LongPressRst = 8'd18;
  localparam cfg_data_t  OffMinARst   = 8'd30;
  localparam cfg_data_t  OffMinBRst   = 8'd60;

  typedef enum logic {
    OP_BUTTON = 1'b0,
    OP_CLOCK  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    LIGHT_OFF    = 2'd0,
    LIGHT_STEADY = 2'd1,
    LIGHT_ANIM   = 2'd2
  } light_mode_t;

  typedef enum logic [1:0] {
    SLEEP_NONE = 2'd0,
    SLEEP_A    = 2'd1,
    SLEEP_B    = 2'd2
  } sleep_mode_t;

  typedef enum logic [1:0] {
    CFG_LONG_PRESS = 2'd0,
    CFG_OFF_MIN_A  = 2'd1,
    CFG_OFF_MIN_B  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    op_t  operation;
    logic power_pressed;
    logic light_pressed;
    logic sleep_pressed;
  } item_t;

  // Lamp state after one beat, handed from the core to the result stage.
  typedef struct packed {
    logic        power_on;
    light_mode_t light_mode;
    step_t       step;
    logic        ramp_down;
    sleep_mode_t sleep_mode;
    logic        heartbeat;
  } status_t;

  typedef struct packed {
    level_t red;
    level_t green;
  } rgb_t;

  typedef struct packed {
    logic        power_on;
    light_mode_t light_mode;
    step_t       bright_level;
    logic        ramp_down;
    sleep_mode_t sleep_mode;
    logic        sleep_led_a;
    logic        sleep_led_b;
    logic        status_led;
    level_t      red_level;
    level_t      green_level;
  } result_t;

  localparam rgb_t LampRom [RomDepth] = '{
    '{8'd240, 8'd150}, '{8'd221, 8'd139}, '{8'd204, 8'd127}, '{8'd187, 8'd117},
    '{8'd172, 8'd108}, '{8'd159, 8'd99},  '{8'd146, 8'd91},  '{8'd134, 8'd84},
    '{8'd124, 8'd77},  '{8'd114, 8'd71},  '{8'd105, 8'd66},  '{8'd96,  8'd60},
    '{8'd89,  8'd56},  '{8'd82,  8'd51},  '{8'd75,  8'd47},  '{8'd69,  8'd43},
    '{8'd64,  8'd40},  '{8'd59,  8'd37},  '{8'd54,  8'd34},  '{8'd50,  8'd31},
    '{8'd46,  8'd29},  '{8'd42,  8'd27},  '{8'd39,  8'd24},  '{8'd36,  8'd23},
    '{8'd33,  8'd21},  '{8'd30,  8'd19},  '{8'd28,  8'd18},  '{8'd26,  8'd16},
    '{8'd24,  8'd15},  '{8'd22,  8'd14},  '{8'd20,  8'd13},  '{8'd19,  8'd12},
    '{8'd17,  8'd11},  '{8'd16,  8'd10},  '{8'd15,  8'd9},   '{8'd13,  8'd9},
    '{8'd12,  8'd8},   '{8'd11,  8'd7},   '{8'd11,  8'd7},   '{8'd10,  8'd6},
    '{8'd9,   8'd6}
  };

  // Steps past the end of the table read its last entry.
  function automatic rgb_t rom_lookup(step_t step);
    step_t idx;
    idx = (step > RomLast) ? RomLast : step;
    return LampRom[idx];
  endfunction

  // True on the nonzero multiples of the blink period that fit in a 7-bit tick value.
  function automatic logic blink_due(tick_t t);
    return (t == BlinkTicks) || (t == tick_t'(2 * BlinkTicks)) ||
           (t == tick_t'(3 * BlinkTicks)) || (t == tick_t'(4 * BlinkTicks)) ||
           (t == tick_t'(5 * BlinkTicks)) || (t == tick_t'(6 * BlinkTicks));
  endfunction

  function automatic light_mode_t next_light(light_mode_t m);
    light_mode_t r;
    case (m)
      LIGHT_OFF:    r = LIGHT_STEADY;
      LIGHT_STEADY: r = LIGHT_ANIM;
      default:      r = LIGHT_OFF;
    endcase
    return r;
  endfunction

  function automatic sleep_mode_t next_sleep(sleep_mode_t m);
    sleep_mode_t r;
    case (m)
      SLEEP_NONE: r = SLEEP_A;
      SLEEP_A:    r = SLEEP_B;
      default:    r = SLEEP_NONE;
    endcase
    return r;
  endfunction

endpackage

// File: src/tblc_in_if.sv
interface tblc_in_if;
  import tblc_pkg::*;

  logic valid;
  logic ready;
  op_t  operation;
  logic power_pressed;
  logic light_pressed;
  logic sleep_pressed;

  modport source (output valid, operation, power_pressed, light_pressed, sleep_pressed,
                  input ready);
  modport sink   (input valid, operation, power_pressed, light_pressed, sleep_pressed,
                  output ready);
endinterface

// File: src/tblc_out_if.sv
interface tblc_out_if;
  import tblc_pkg::*;

  logic        valid;
  logic        ready;
  logic        power_on;
  light_mode_t light_mode;
  step_t       bright_level;
  logic        ramp_down;
  sleep_mode_t sleep_mode;
  logic        sleep_led_a;
  logic        sleep_led_b;
  logic        status_led;
  level_t      red_level;
  level_t      green_level;

  modport source (output valid, power_on, light_mode, bright_level, ramp_down, sleep_mode,
                         sleep_led_a, sleep_led_b, status_led, red_level, green_level,
                  input  ready);
  modport sink   (input  valid, power_on, light_mode, bright_level, ramp_down, sleep_mode,
                         sleep_led_a, sleep_led_b, status_led, red_level, green_level,
                  output ready);
endinterface

// File: src/tblc_cfg_if.sv
interface tblc_cfg_if;
  import tblc_pkg::*;

  logic      valid;
  logic      ready;
  cfg_addr_t index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/three_button_lamp_controller.sv
// Three-button lamp controller. Each input beat is either a button-sample tick
// (operation 0, nominally every 50 ms, carrying the power, light and timer button
// levels) or a 10 ms clock tick (operation 1); every beat yields exactly one
// result beat holding the lamp state after that tick: power, light mode,
// brightness step and ramp direction, auto-off mode with its two indicator LEDs,
// the heartbeat status LED and the steady red/green levels from the brightness
// table. Throughput is one beat per clock while the sink does not stall. An
// accepted beat sits in the input register, and one update pass of the state
// registers loads the result register with its outcome. A waiting result
// does not block the input register, so one more beat is taken while the
// sink stalls. The three registers (long-press count, auto-off minutes A and
// B) are written over the configuration channel, which is always ready; write
// them only while no beat is in flight.
`include "assert_macros.svh"

module three_button_lamp_controller (
  input  logic      clk,
  input  logic      rst,
  tblc_in_if.sink   items,
  tblc_out_if.source results,
  tblc_cfg_if.sink  cfg
);
  import tblc_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    out_free;
  logic    take;
  status_t status_next;

  // Advance a held beat whenever the result register can take its outcome.
  assign take = item_valid && out_free;

  // Input register: parts the source from the update pass.
  tblc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .take       (take),
    .item       (item),
    .item_valid (item_valid)
  );

  // Button and clock state, configuration registers, next-state logic.
  tblc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item        (item),
    .take        (take),
    .status_next (status_next)
  );

  // Result register: formats LEDs and table levels, then holds the beat.
  tblc_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .status_next (status_next),
    .results     (results),
    .free        (out_free)
  );

  `TBLC_ASSERT_NEXT(a_take_gives_result, take, results.valid,
    "advanced beat produced no result")
  `TBLC_ASSERT_NOW(a_no_take_when_blocked, results.valid && !results.ready, !take,
    "result overwritten while stalled")
  `TBLC_ASSERT_NOW(a_levels_need_steady, results.valid && (results.red_level != '0),
    results.power_on && (results.light_mode == LIGHT_STEADY), "lamp lit outside steady mode")
endmodule

// File: src/tblc_in_stage.sv
module tblc_in_stage (
  input  logic            clk,
  input  logic            rst,
  tblc_in_if.sink         items,
  input  logic            take,
  output tblc_pkg::item_t item,
  output logic            item_valid
);
  import tblc_pkg::*;

  logic valid;

  // Open for a new beat when empty or when the held one moves on.
  assign items.ready = !valid || take;
  assign item_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (items.ready) begin
      valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      item <= '{operation:     items.operation,
                power_pressed: items.power_pressed,
                light_pressed: items.light_pressed,
                sleep_pressed: items.sleep_pressed};
    end
  end
endmodule

// File: src/tblc_core.sv
`include "assert_macros.svh"

module tblc_core (
  input  logic              clk,
  input  logic              rst,
  tblc_cfg_if.sink          cfg,
  input  tblc_pkg::item_t   item,
  input  logic              take,
  output tblc_pkg::status_t status_next
);
  import tblc_pkg::*;

  cfg_data_t   long_press_ticks;
  cfg_data_t   off_minutes_a;
  cfg_data_t   off_minutes_b;

  logic        power_held,       power_held_next;
  hold_cnt_t   power_hold_count, power_hold_count_next;
  logic        light_held,       light_held_next;
  light_cnt_t  light_hold_count, light_hold_count_next;
  logic        sleep_held,       sleep_held_next;
  hold_cnt_t   sleep_hold_count, sleep_hold_count_next;
  logic        power_state,      power_state_next;
  light_mode_t mode_of_light,    mode_of_light_next;
  sleep_mode_t mode_of_sleep,    mode_of_sleep_next;
  logic        direction_down,   direction_down_next;
  step_t       brightness_step,  brightness_step_next;
  tick_t       tick_count,       tick_count_next;
  sec_t        second_count,     second_count_next;
  min_t        minute_count,     minute_count_next;
  logic        heartbeat,        heartbeat_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LongPressRst;
      off_minutes_a    <= OffMinARst;
      off_minutes_b    <= OffMinBRst;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_LONG_PRESS: long_press_ticks <= cfg.data;
        CFG_OFF_MIN_A:  off_minutes_a    <= cfg.data;
        CFG_OFF_MIN_B:  off_minutes_b    <= cfg.data;
        default:        ;
      endcase
    end
  end

  always_comb begin
    logic       light_active;
    light_cnt_t light_inc;
    tick_t      tick_inc;
    sec_t       sec_tmp;

    power_held_next       = power_held;
    power_hold_count_next = power_hold_count;
    light_held_next       = light_held;
    light_hold_count_next = light_hold_count;
    sleep_held_next       = sleep_held;
    sleep_hold_count_next = sleep_hold_count;
    power_state_next      = power_state;
    mode_of_light_next    = mode_of_light;
    mode_of_sleep_next    = mode_of_sleep;
    direction_down_next   = direction_down;
    brightness_step_next  = brightness_step;
    tick_count_next       = tick_count;
    second_count_next     = second_count;
    minute_count_next     = minute_count;
    heartbeat_next        = heartbeat;
    light_active          = 1'b0;
    light_inc             = light_hold_count;
    tick_inc              = tick_count;
    sec_tmp               = second_count;

    if (item.operation == OP_BUTTON) begin
      // Power button: act on release.
      if (item.power_pressed) begin
        if (!power_held) begin
          power_held_next       = 1'b1;
          power_hold_count_next = '0;
        end else if (power_hold_count < HoldCap) begin
          power_hold_count_next = power_hold_count + 1'b1;
        end
      end else begin
        power_held_next = 1'b0;
        if (power_hold_count != '0) begin
          if (!power_state) begin
            power_state_next     = 1'b1;
            mode_of_light_next   = LIGHT_STEADY;
            brightness_step_next = StepMin;
          end else begin
            power_state_next   = 1'b0;
            mode_of_light_next = LIGHT_OFF;
            mode_of_sleep_next = SLEEP_NONE;
          end
        end
        power_hold_count_next = '0;
      end

      // Light button: ramp while held long, reverse on long release, step the light mode on short release.
      light_active = (mode_of_light_next == LIGHT_STEADY) ||
                     (mode_of_light_next == LIGHT_ANIM);
      if (item.light_pressed) begin
        if (!light_held) begin
          light_held_next       = 1'b1;
          light_hold_count_next = '0;
        end else begin
          light_inc = (light_hold_count < LightCap) ? light_hold_count + 1'b1
                                                    : light_hold_count;
          light_hold_count_next = light_inc;
          if ((light_inc > long_press_ticks) && light_active) begin
            if (!direction_down) begin
              brightness_step_next = (brightness_step_next < StepMax)
                                     ? brightness_step_next + 1'b1 : StepMax;
            end else begin
              brightness_step_next = (brightness_step_next > StepMin)
                                     ? brightness_step_next - 1'b1 : StepMin;
            end
          end
        end
      end else begin
        light_held_next = 1'b0;
        if (light_hold_count != '0) begin
          if (light_hold_count > long_press_ticks) begin
            if (light_active) begin
              direction_down_next = !direction_down;
            end
          end else if (power_state_next) begin
            mode_of_light_next = next_light(mode_of_light_next);
          end
        end
        light_hold_count_next = '0;
      end

      // Timer button: cycle auto-off and restart the clock.
      if (item.sleep_pressed) begin
        if (!sleep_held) begin
          sleep_held_next       = 1'b1;
          sleep_hold_count_next = '0;
        end else if (sleep_hold_count < HoldCap) begin
          sleep_hold_count_next = sleep_hold_count + 1'b1;
        end
      end else begin
        sleep_held_next = 1'b0;
        if ((sleep_hold_count != '0) && power_state_next) begin
          tick_count_next    = '0;
          second_count_next  = '0;
          minute_count_next  = '0;
          mode_of_sleep_next = next_sleep(mode_of_sleep_next);
        end
        sleep_hold_count_next = '0;
      end
    end else begin
      tick_inc = tick_count + 1'b1;
      if (blink_due(tick_inc)) begin
        heartbeat_next = !heartbeat;
      end
      tick_count_next = tick_inc;
      if (tick_inc == TicksPerSec) begin
        sec_tmp         = second_count + 1'b1;
        tick_count_next = '0;
      end
      if (sec_tmp == SecsPerMin) begin
        minute_count_next = minute_count + 1'b1;
        sec_tmp           = '0;
      end
      second_count_next = sec_tmp;

      if (power_state && (((mode_of_sleep == SLEEP_A) && (minute_count_next == off_minutes_a))
          || ((mode_of_sleep == SLEEP_B) && (minute_count_next == off_minutes_b)))) begin
        power_state_next   = 1'b0;
        mode_of_light_next = LIGHT_OFF;
        mode_of_sleep_next = SLEEP_NONE;
      end
      if (!power_state_next && (mode_of_light_next == LIGHT_OFF) &&
          (mode_of_sleep_next == SLEEP_NONE)) begin
        heartbeat_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_held       <= 1'b0;
      power_hold_count <= '0;
      light_held       <= 1'b0;
      light_hold_count <= '0;
      sleep_held       <= 1'b0;
      sleep_hold_count <= '0;
      power_state      <= 1'b0;
      mode_of_light    <= LIGHT_OFF;
      mode_of_sleep    <= SLEEP_NONE;
      direction_down   <= 1'b0;
      brightness_step  <= StepMin;
      tick_count       <= '0;
      second_count     <= '0;
      minute_count     <= '0;
      heartbeat        <= 1'b0;
    end else if (take) begin
      power_held       <= power_held_next;
      power_hold_count <= power_hold_count_next;
      light_held       <= light_held_next;
      light_hold_count <= light_hold_count_next;
      sleep_held       <= sleep_held_next;
      sleep_hold_count <= sleep_hold_count_next;
      power_state      <= power_state_next;
      mode_of_light    <= mode_of_light_next;
      mode_of_sleep    <= mode_of_sleep_next;
      direction_down   <= direction_down_next;
      brightness_step  <= brightness_step_next;
      tick_count       <= tick_count_next;
      second_count     <= second_count_next;
      minute_count     <= minute_count_next;
      heartbeat        <= heartbeat_next;
    end
  end

  assign status_next = '{power_on:   power_state_next,
                         light_mode: mode_of_light_next,
                         step:       brightness_step_next,
                         ramp_down:  direction_down_next,
                         sleep_mode: mode_of_sleep_next,
                         heartbeat:  heartbeat_next};

  `TBLC_ASSERT_NOW(a_step_range, 1'b1, (brightness_step >= StepMin) && (brightness_step <= StepMax), "brightness step out of range")
  `TBLC_ASSERT_NOW(a_off_clears_modes, !power_state, (mode_of_light == LIGHT_OFF) && (mode_of_sleep == SLEEP_NONE), "modes left set while power is off")
  `TBLC_ASSERT_NOW(a_clock_bounds, 1'b1, (tick_count < TicksPerSec) && (second_count < SecsPerMin), "tick or second count past its wrap")
  `TBLC_ASSERT_NEXT(a_idle_holds_state, !take && !cfg.valid, $stable(brightness_step) && $stable(power_state) && $stable(minute_count), "state moved without a beat")
endmodule

// File: src/tblc_out_stage.sv
module tblc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  tblc_pkg::status_t status_next,
  tblc_out_if.source        results,
  output logic              free
);
  import tblc_pkg::*;

  logic    valid;
  result_t result;
  result_t result_next;
  rgb_t    rgb;
  logic    steady;

  assign free = !valid || results.ready;

  always_comb begin
    rgb    = rom_lookup(status_next.step);
    steady = status_next.power_on && (status_next.light_mode == LIGHT_STEADY);
    result_next = '{power_on:     status_next.power_on,
                    light_mode:   status_next.light_mode,
                    bright_level: status_next.step,
                    ramp_down:    status_next.ramp_down,
                    sleep_mode:   status_next.sleep_mode,
                    sleep_led_a:  status_next.power_on && (status_next.sleep_mode == SLEEP_A),
                    sleep_led_b:  status_next.power_on && (status_next.sleep_mode == SLEEP_B),
                    status_led:   status_next.power_on && status_next.heartbeat,
                    red_level:    steady ? rgb.red   : '0,
                    green_level:  steady ? rgb.green : '0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  assign results.valid        = valid;
  assign results.power_on     = result.power_on;
  assign results.light_mode   = result.light_mode;
  assign results.bright_level = result.bright_level;
  assign results.ramp_down    = result.ramp_down;
  assign results.sleep_mode   = result.sleep_mode;
  assign results.sleep_led_a  = result.sleep_led_a;
  assign results.sleep_led_b  = result.sleep_led_b;
  assign results.status_led   = result.status_led;
  assign results.red_level    = result.red_level;
  assign results.green_level  = result.green_level;
endmodule
